@@ rtl/core/vrt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrt_pkg
// Types, codes and defaults shared by the region table and its cells.
// ----------------------------------------------------------------------------
package vrt_pkg;

  localparam int DEF_MAX_REGIONS = 16;
  localparam int DEF_PAGE_SHIFT  = 12;

  localparam int FLAG_R = 0;
  localparam int FLAG_W = 1;
  localparam int FLAG_X = 2;

  localparam int EC_PRESENT = 0;
  localparam int EC_WRITE   = 1;

  localparam logic [2:0] PERM_WRITABLE = 3'h2;
  localparam logic [2:0] PERM_USER     = 3'h4;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_LOOKUP = 2'd1,
    ACT_FAULT  = 2'd2,
    ACT_NOP    = 2'd3
  } vrt_action_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_REGION = 3'd1,
    ST_DENIED    = 3'd2,
    ST_BAD_RANGE = 3'd3,
    ST_FULL      = 3'd4
  } vrt_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_FIN
  } vrt_state_t;

  typedef struct packed {
    logic [31:0] start_addr;
    logic [31:0] end_addr;
    logic [2:0]  flags;
  } vrt_region_t;

  // operands broadcast to every cell
  typedef struct packed {
    logic        cmp_en;
    logic        ins_en;
    vrt_region_t region;
  } vrt_cell_op_t;

  // what a cell hands to its right neighbor
  typedef struct packed {
    logic        valid;
    logic        le;
    vrt_region_t region;
  } vrt_link_t;

endpackage

`default_nettype wire

@@ rtl/core/vrt_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrt_if
// Request and response channels of the region table.
// ----------------------------------------------------------------------------
interface vrt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] addr;
  logic [31:0] region_end_in;
  logic [2:0]  region_flags_in;
  logic [2:0]  fault_code;

  modport source (
    output valid, action, addr, region_end_in, region_flags_in, fault_code,
    input  ready
  );
  modport sink (
    input  valid, action, addr, region_end_in, region_flags_in, fault_code,
    output ready
  );
endinterface

interface vrt_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        hit;
  logic [31:0] found_start;
  logic [31:0] found_end;
  logic [2:0]  found_flags;
  logic [2:0]  page_perm;
  logic [31:0] page_base;
  logic [4:0]  region_total;
  logic [31:0] fault_total;

  modport source (
    output valid, status, hit, found_start, found_end, found_flags,
           page_perm, page_base, region_total, fault_total,
    input  ready
  );
  modport sink (
    input  valid, status, hit, found_start, found_end, found_flags,
           page_perm, page_base, region_total, fault_total,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/core/vm_region_table_fault_check.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vm_region_table_fault_check
// Sorted table of virtual memory regions with insert, lookup and page fault
// permission check, built as a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Flow: a request is accepted in S_IDLE or S_FIN, then passes S_CMP (parallel
//   compare in the cells) and S_FIN (select, check and shift), which waits while
//   the last response is not yet taken; the next request is accepted at commit.
// Reset clears the region count, the cell valid bits, the fault counter and
//   the response valid; region contents are undefined until inserted.
module vm_region_table_fault_check import vrt_pkg::*; #(
  parameter int MAX_REGIONS = DEF_MAX_REGIONS,
  parameter int PAGE_SHIFT  = DEF_PAGE_SHIFT
) (
  input  wire logic clk,
  input  wire logic rst,
  vrt_req_if.sink   req,
  vrt_rsp_if.source rsp
);

  localparam int CNT_W = $clog2(MAX_REGIONS + 1);
  localparam logic [31:0] PAGE_MASK = ~((32'd1 << PAGE_SHIFT) - 32'd1);

  vrt_state_t state, state_next;

  vrt_action_t op_action;
  vrt_region_t op_region;
  logic [2:0]  op_ecode;

  logic [CNT_W-1:0] count;
  logic [31:0]      fault_count;

  logic out_free;
  logic accept;
  logic commit;

  vrt_cell_op_t cell_op;
  vrt_link_t    links [MAX_REGIONS+1];
  logic [MAX_REGIONS-1:0] hits;
  logic [MAX_REGIONS-1:0] ovls;

  logic        hit_any;
  logic        ovl_any;
  vrt_region_t found;

  vrt_status_t      res_status;
  logic             res_hit;
  vrt_region_t      res_region;
  logic [2:0]       res_perm;
  logic [31:0]      res_base;
  logic             ins_ok;
  logic             fault_ok;
  logic [CNT_W-1:0] count_next;
  logic [31:0]      fault_count_next;
  logic [CNT_W+4:0] count_ext;

  assign out_free = !rsp.valid || rsp.ready;
  assign accept   = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    commit     = 1'b0;
    unique case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        state_next = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          commit     = 1'b1;
          req.ready  = 1'b1;
          state_next = req.valid ? S_CMP : S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_action            <= vrt_action_t'(req.action);
      op_region.start_addr <= req.addr;
      op_region.end_addr   <= req.region_end_in;
      op_region.flags      <= req.region_flags_in;
      op_ecode             <= req.fault_code;
    end
  end

  // cell row
  assign cell_op.cmp_en = (state == S_CMP);
  assign cell_op.ins_en = commit && ins_ok;
  assign cell_op.region = op_region;

  assign links[0].valid  = 1'b1;
  assign links[0].le     = 1'b1;
  assign links[0].region = op_region;

  for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
    vrt_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .op   (cell_op),
      .prev (links[i]),
      .link (links[i+1]),
      .hit  (hits[i]),
      .ovl  (ovls[i])
    );
  end

  // regions never overlap, so at most one cell hits
  always_comb begin
    found = '0;
    for (int i = 0; i < MAX_REGIONS; i++) begin
      found = found | (hits[i] ? links[i+1].region : '0);
    end
    hit_any = |hits;
    ovl_any = |ovls;
  end

  always_comb begin
    res_status       = ST_OK;
    res_hit          = 1'b0;
    res_region       = '0;
    res_perm         = '0;
    res_base         = '0;
    ins_ok           = 1'b0;
    fault_ok         = 1'b0;
    fault_count_next = fault_count;
    unique case (op_action)
      ACT_INSERT: begin
        priority if (op_region.start_addr >= op_region.end_addr) begin
          res_status = ST_BAD_RANGE;
        end else if (count == CNT_W'(MAX_REGIONS)) begin
          res_status = ST_FULL;
        end else if (ovl_any) begin
          res_status = ST_BAD_RANGE;
        end else begin
          ins_ok = 1'b1;
        end
      end
      ACT_LOOKUP: begin
        if (hit_any) begin
          res_hit    = 1'b1;
          res_region = found;
        end else begin
          res_status = ST_NO_REGION;
        end
      end
      ACT_FAULT: begin
        fault_count_next = fault_count + 32'd1;
        if (hit_any) begin
          res_hit    = 1'b1;
          res_region = found;
          priority if (op_ecode[EC_WRITE]) begin
            fault_ok = found.flags[FLAG_W];
          end else if (op_ecode[EC_PRESENT]) begin
            fault_ok = 1'b0;
          end else begin
            fault_ok = found.flags[FLAG_R] || found.flags[FLAG_X];
          end
          if (fault_ok) begin
            res_perm = PERM_USER | (found.flags[FLAG_W] ? PERM_WRITABLE : 3'h0);
            res_base = op_region.start_addr & PAGE_MASK;
          end else begin
            res_status = ST_DENIED;
          end
        end else begin
          res_status = ST_NO_REGION;
        end
      end
      ACT_NOP: begin
      end
      default: begin
      end
    endcase
    count_next = ins_ok ? count + CNT_W'(1) : count;
    count_ext  = {5'd0, count_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      fault_count <= '0;
      rsp.valid   <= 1'b0;
    end else begin
      if (commit) begin
        count       <= count_next;
        fault_count <= fault_count_next;
        rsp.valid   <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      rsp.status       <= res_status;
      rsp.hit          <= res_hit;
      rsp.found_start  <= res_region.start_addr;
      rsp.found_end    <= res_region.end_addr;
      rsp.found_flags  <= res_region.flags;
      rsp.page_perm    <= res_perm;
      rsp.page_base    <= res_base;
      rsp.region_total <= count_ext[4:0];
      rsp.fault_total  <= fault_count_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/vrt_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrt_cell
// One table slot: holds a region, compares it against the broadcast item and
// on insert keeps its region, takes the new one or takes its left neighbor's.
// ----------------------------------------------------------------------------
module vrt_cell import vrt_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire vrt_cell_op_t op,
  input  wire vrt_link_t    prev,
  output vrt_link_t         link,
  output logic              hit,
  output logic              ovl
);

  logic        valid;
  logic        le;
  vrt_region_t region;

  logic cmp_le;
  logic cmp_hit;
  logic cmp_ahead;

  always_comb begin
    cmp_le    = valid && (region.start_addr <= op.region.start_addr);
    cmp_hit   = cmp_le && (op.region.start_addr < region.end_addr);
    cmp_ahead = valid && (op.region.start_addr < region.start_addr) &&
                (region.start_addr < op.region.end_addr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      le    <= 1'b0;
      hit   <= 1'b0;
      ovl   <= 1'b0;
    end else begin
      if (op.cmp_en) begin
        le  <= cmp_le;
        hit <= cmp_hit;
        ovl <= cmp_hit || cmp_ahead;
      end
      if (op.ins_en && !le) begin
        valid <= prev.le ? 1'b1 : prev.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op.ins_en && !le) begin
      region <= prev.le ? op.region : prev.region;
    end
  end

  assign link.valid  = valid;
  assign link.le     = le;
  assign link.region = region;

endmodule

`default_nettype wire
